// ----- rtl/core/wtsc_pkg.sv -----
// shared types, constants and helpers for the wavetable sound channel
`timescale 1ns / 1ps

package wtsc_pkg;

    localparam int WAVE_BYTES = 16;
    localparam int WAVE_AW = $clog2(WAVE_BYTES);

    localparam logic [2:0] ACT_PERIOD = 3'd0;
    localparam logic [2:0] ACT_LENGTH = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_READ = 3'd3;
    localparam logic [2:0] ACT_OFF = 3'd4;

    localparam logic [5:0] REG_DAC = 6'd0;
    localparam logic [5:0] REG_LEN = 6'd1;
    localparam logic [5:0] REG_VOL = 6'd2;
    localparam logic [5:0] REG_FLO = 6'd3;
    localparam logic [5:0] REG_FHI = 6'd4;
    localparam logic [5:0] WAVE_BASE = 6'h16;
    localparam logic [5:0] WAVE_END = 6'(WAVE_BASE + WAVE_BYTES);

    localparam logic [12:0] TIMER_RESET = 13'd4096;
    localparam logic [8:0] LEN_FULL = 9'd256;
    localparam logic [7:0] READ_IDLE = 8'hFF;

    typedef enum logic [1:0] {
        SK_HOLD,
        SK_ZERO,
        SK_NIBBLE
    } sample_kind_t;

    typedef struct packed {
        logic              mem_we;
        logic              mem_re;
        logic [WAVE_AW-1:0] mem_addr;
        logic [7:0]        mem_wdata;
        sample_kind_t      kind;
        logic              nib_low;
        logic [1:0]        vol;
        logic              use_mem;
        logic [7:0]        rd;
    } req_t;

    function automatic logic [12:0] reload_of(input logic [10:0] freq);
        logic [11:0] diff;
        diff = 12'(12'h800 - {1'b0, freq});
        return {diff, 1'b0};
    endfunction

endpackage

// ----- rtl/core/wavetable_sound_channel_top.sv -----
// wavetable sound channel: control decode, wave store memory and output stage
// an accepted item is held in the memory stage register, then registered into the output register
// throughput: one item per cycle while the input is not stalled, set by the single read/write port of the wave store
// input stalls only while both the memory stage and the output register are full
// reset: asynchronous, clears control state (timer to TIMER_RESET) and sample to zero, wave store reads zero
`timescale 1ns / 1ps

module wavetable_sound_channel_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] action,
    input  logic [5:0] reg_index,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic [3:0] sample
);
    import wtsc_pkg::*;

    req_t              req;
    logic              accept;
    logic              s1_adv;
    logic [7:0]        mem [WAVE_BYTES];
    logic [WAVE_BYTES-1:0] wv_reg;
    logic [7:0]        rdata_reg;
    logic              rv_reg;
    logic              s1_valid_reg;
    sample_kind_t      s1_kind_reg;
    logic              s1_nib_low_reg;
    logic [1:0]        s1_vol_reg;
    logic              s1_use_mem_reg;
    logic [7:0]        s1_rd_reg;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg;
    logic [3:0]        sample_reg;
    logic [7:0]        wave_byte;
    logic [3:0]        nib;
    logic [3:0]        sample_next;

    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;
    assign s1_adv = s1_valid_reg && (!out_valid_reg || !out_stall);

    wtsc_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (action),
        .reg_index  (reg_index),
        .write_data (write_data),
        .req        (req)
    );

    always_ff @(posedge clk)
    begin
        if (req.mem_we)
        begin
            mem[req.mem_addr] <= req.mem_wdata;
        end
        if (req.mem_re)
        begin
            rdata_reg <= mem[req.mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= '0;
            rv_reg <= 1'b0;
        end
        else
        begin
            if (req.mem_we)
            begin
                wv_reg[req.mem_addr] <= 1'b1;
            end
            if (req.mem_re)
            begin
                rv_reg <= wv_reg[req.mem_addr];
            end
        end
    end

    assign wave_byte = rv_reg ? rdata_reg : 8'd0;
    assign nib = s1_nib_low_reg ? wave_byte[3:0] : wave_byte[7:4];

    always_comb
    begin
        case (s1_kind_reg)
            SK_ZERO: sample_next = 4'd0;
            SK_NIBBLE:
            begin
                if (s1_vol_reg == 2'd0)
                begin
                    sample_next = 4'd0;
                end
                else
                begin
                    sample_next = nib >> (s1_vol_reg - 2'd1);
                end
            end
            default: sample_next = sample_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            sample_reg <= 4'd0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                sample_reg <= sample_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= req.kind;
            s1_nib_low_reg <= req.nib_low;
            s1_vol_reg <= req.vol;
            s1_use_mem_reg <= req.use_mem;
            s1_rd_reg <= req.rd;
        end
        if (s1_adv)
        begin
            read_data_reg <= s1_use_mem_reg ? wave_byte : s1_rd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign sample = sample_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.mem_we && req.mem_re))
        else $error("wave store read and write in one cycle");

    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> ($stable(rdata_reg) && $stable(rv_reg)))
        else $error("wave data changed under a held item");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before memory stage");

endmodule

// ----- rtl/core/wtsc_regs.sv -----
// control registers, timers and request decode for one accepted item
`timescale 1ns / 1ps

module wtsc_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [2:0]        action,
    input  logic [5:0]        reg_index,
    input  logic [7:0]        write_data,
    output wtsc_pkg::req_t    req
);
    import wtsc_pkg::*;

    logic [12:0] timer_reg, timer_next;
    logic [10:0] freq_reg, freq_next;
    logic [4:0]  pos_reg, pos_next;
    logic        chan_reg, chan_next;
    logic        dac_reg, dac_next;
    logic [1:0]  vol_reg, vol_next;
    logic        len_on_reg, len_on_next;
    logic [8:0]  len_reg, len_next;
    logic [12:0] timer_dec;
    logic [5:0]  wave_off;
    logic        in_wave;

    assign timer_dec = timer_reg - 13'd1;
    assign wave_off = reg_index - WAVE_BASE;
    assign in_wave = (reg_index >= WAVE_BASE) && (reg_index < WAVE_END);

    always_comb
    begin
        timer_next = timer_reg;
        freq_next = freq_reg;
        pos_next = pos_reg;
        chan_next = chan_reg;
        dac_next = dac_reg;
        vol_next = vol_reg;
        len_on_next = len_on_reg;
        len_next = len_reg;
        req = '0;
        req.kind = SK_HOLD;
        req.rd = READ_IDLE;
        req.vol = vol_reg;
        if (accept)
        begin
            unique case (action)
                ACT_PERIOD:
                begin
                    if (timer_dec == 13'd0)
                    begin
                        timer_next = reload_of(freq_reg);
                        if (chan_reg && dac_reg)
                        begin
                            pos_next = pos_reg + 5'd1;
                            req.mem_re = 1'b1;
                            req.mem_addr = pos_next[4:1];
                            req.kind = SK_NIBBLE;
                            req.nib_low = pos_next[0];
                        end
                        else
                        begin
                            req.kind = SK_ZERO;
                        end
                    end
                    else
                    begin
                        timer_next = timer_dec;
                    end
                end
                ACT_LENGTH:
                begin
                    if (len_on_reg && (len_reg != 9'd0))
                    begin
                        len_next = len_reg - 9'd1;
                        if (len_next == 9'd0)
                        begin
                            chan_next = 1'b0;
                        end
                    end
                end
                ACT_WRITE:
                begin
                    unique case (reg_index)
                        REG_DAC: dac_next = write_data[7];
                        REG_LEN: len_next = LEN_FULL - {1'b0, write_data};
                        REG_VOL: vol_next = write_data[6:5];
                        REG_FLO: freq_next = {freq_reg[10:8], write_data};
                        REG_FHI:
                        begin
                            freq_next = {write_data[2:0], freq_reg[7:0]};
                            len_on_next = write_data[6];
                            if (write_data[7])
                            begin
                                chan_next = 1'b1;
                                timer_next = reload_of(freq_next);
                                pos_next = 5'd0;
                                if (len_reg == 9'd0)
                                begin
                                    len_next = LEN_FULL;
                                end
                            end
                        end
                        default:
                        begin
                            if (in_wave)
                            begin
                                req.mem_we = 1'b1;
                                req.mem_addr = wave_off[WAVE_AW-1:0];
                                req.mem_wdata = write_data;
                            end
                        end
                    endcase
                end
                ACT_READ:
                begin
                    unique case (reg_index)
                        REG_DAC: req.rd = {dac_reg, 7'h7F};
                        REG_VOL: req.rd = {1'b1, vol_reg, 5'h1F};
                        REG_FHI: req.rd = {1'b1, len_on_reg, 3'b111, freq_reg[10:8]};
                        default:
                        begin
                            if (in_wave)
                            begin
                                req.mem_re = 1'b1;
                                req.mem_addr = wave_off[WAVE_AW-1:0];
                                req.use_mem = 1'b1;
                            end
                        end
                    endcase
                end
                ACT_OFF:
                begin
                    timer_next = TIMER_RESET;
                    freq_next = 11'd0;
                    pos_next = 5'd0;
                    chan_next = 1'b0;
                    dac_next = 1'b0;
                    vol_next = 2'd0;
                    len_on_next = 1'b0;
                    len_next = 9'd0;
                    req.kind = SK_ZERO;
                end
                default:
                begin
                    req.kind = SK_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= TIMER_RESET;
            freq_reg <= 11'd0;
            pos_reg <= 5'd0;
            chan_reg <= 1'b0;
            dac_reg <= 1'b0;
            vol_reg <= 2'd0;
            len_on_reg <= 1'b0;
            len_reg <= 9'd0;
        end
        else
        begin
            timer_reg <= timer_next;
            freq_reg <= freq_next;
            pos_reg <= pos_next;
            chan_reg <= chan_next;
            dac_reg <= dac_next;
            vol_reg <= vol_next;
            len_on_reg <= len_on_next;
            len_reg <= len_next;
        end
    end

endmodule
